// File: design/ilt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilt_pkg;

	// Default sizing
	localparam int ILT_MAX_DEPTH    = 32;
	localparam int ILT_MAX_LINE_LEN = 1024;
	// Leading whitespace counters never go above this, whatever the line length
	localparam int ILT_COUNT_LIMIT  = 1023;

	// Token kinds
	localparam logic [2:0] TK_INDENT  = 3'd0;
	localparam logic [2:0] TK_DEDENT  = 3'd1;
	localparam logic [2:0] TK_NEWLINE = 3'd2;
	localparam logic [2:0] TK_END     = 3'd3;
	localparam logic [2:0] TK_ERROR   = 3'd4;

	// Error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_MIXED    = 3'd1;
	localparam logic [2:0] ERR_NOT_MULT = 3'd2;
	localparam logic [2:0] ERR_JUMP     = 3'd3;
	localparam logic [2:0] ERR_DEEP     = 3'd4;

	// Characters
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_VT      = 8'h0B;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_COMMENT = 8'h3B;

	typedef enum logic [1:0] {
		STYLE_UNSET,
		STYLE_TABS,
		STYLE_SPACES
	} style_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_LEAD,
		PH_BODY,
		PH_SKIP
	} phase_t;

endpackage

`default_nettype wire

// File: design/ilt_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle on a single subtractor.
module ilt_div #(
	parameter int W = 10
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic      [W-1:0] quotient,
	output logic      [W-1:0] remainder
);

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    partial;
	logic [W:0]    trial;

	assign partial = {rem_q, quo_q[W-1]};
	assign trial   = partial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= partial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// File: design/indent_layout_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// src      in         src_valid/src_stall  command, source_byte
// tok      out        tok_valid/tok_stall  token_kind, error_code, line_number, last_of_run
//
// An ordinary byte is accepted in S_IDLE and decoded in S_DECODE; src is stalled meanwhile.
// The first content byte of a line adds a compare step in S_JUDGE, and under space style
// first a divide step in S_DIVIDE on the divider, whose width W is the counter width (10 by default).
// The emit sequencer loads each layout token into the output register once that register is free.
// arst_n clears all line, style, depth and halt state at once; no clearing pass.
// tok_stall holds the token register; the sequencer waits, src is stalled until done.
module indent_layout_tokenizer_top
	import ilt_pkg::*;
#(
	parameter int MAX_DEPTH    = ILT_MAX_DEPTH,
	parameter int MAX_LINE_LEN = ILT_MAX_LINE_LEN
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic        command,
	input  wire logic [7:0]  source_byte,
	output logic             tok_valid,
	input  wire logic        tok_stall,
	output logic      [2:0]  token_kind,
	output logic      [2:0]  error_code,
	output logic      [15:0] line_number,
	output logic             last_of_run
);

	localparam int COUNT_CAP = (MAX_LINE_LEN - 1 < ILT_COUNT_LIMIT) ?
		(MAX_LINE_LEN - 1) : ILT_COUNT_LIMIT;
	localparam int CNT_W = $clog2(COUNT_CAP + 1);
	localparam int DW    = $clog2(MAX_DEPTH);
	localparam int LW    = ((CNT_W > DW) ? CNT_W : DW) + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DIVIDE,
		S_JUDGE,
		S_INDENT,
		S_DEDENT,
		S_NEWLINE,
		S_END,
		S_ERROR
	} state_t;

	state_t           state_q;
	logic             cmd_q;
	logic [7:0]       byte_q;
	phase_t           phase_q;
	style_t           style_q;
	logic [CNT_W-1:0] sp_q;
	logic [CNT_W-1:0] tb_q;
	logic [CNT_W-1:0] spl_q;
	logic [DW-1:0]    depth_q;
	logic [15:0]      line_q;
	logic             halted_q;
	logic [LW-1:0]    level_q;
	logic [2:0]       err_q;

	logic             tok_valid_q;
	logic [2:0]       tok_kind_q;
	logic [2:0]       tok_err_q;
	logic [15:0]      tok_line_q;
	logic             tok_last_q;

	logic             slot_free;
	logic             emit_want;
	logic             tok_load;
	logic             is_nl, is_sp, is_tab, is_ws, is_comment;
	logic             content_hit;
	logic             mixed;
	style_t           style_nx;
	logic [CNT_W-1:0] spl_nx;
	logic [15:0]      line_inc;
	logic [LW-1:0]    depth_ext;
	logic             div_start;
	logic             div_done;
	logic [CNT_W-1:0] div_quo;
	logic [CNT_W-1:0] div_rem;

	assign src_stall = (state_q != S_IDLE);
	assign slot_free = !tok_valid_q || !tok_stall;
	assign emit_want = (state_q == S_INDENT) || (state_q == S_DEDENT) ||
		(state_q == S_NEWLINE) || (state_q == S_END) || (state_q == S_ERROR);
	assign tok_load  = emit_want && slot_free;

	assign is_nl      = (byte_q == CH_NL);
	assign is_sp      = (byte_q == CH_SPACE);
	assign is_tab     = (byte_q == CH_TAB);
	assign is_ws      = (byte_q >= CH_VT) && (byte_q <= CH_CR);
	assign is_comment = (byte_q == CH_COMMENT) || (byte_q == CH_NUL);
	assign mixed      = (sp_q != '0) && (tb_q != '0);
	assign line_inc   = (line_q == 16'hFFFF) ? line_q : line_q + 16'd1;
	assign depth_ext  = LW'(depth_q);

	// First content byte of a line in leading whitespace
	assign content_hit = (state_q == S_DECODE) && !halted_q && !cmd_q && !is_nl &&
		((phase_q == PH_START) || (phase_q == PH_LEAD)) &&
		!is_sp && !is_tab && !is_ws && !is_comment;

	// The first purely indented line fixes the style
	always_comb begin
		style_nx = style_q;
		spl_nx   = spl_q;
		if ((style_q == STYLE_UNSET) && ((sp_q != '0) != (tb_q != '0))) begin
			if (sp_q != '0) begin
				style_nx = STYLE_SPACES;
				spl_nx   = sp_q;
			end else begin
				style_nx = STYLE_TABS;
			end
		end
	end

	assign div_start = content_hit && !mixed && (style_nx == STYLE_SPACES) && (spl_nx != '0);

	ilt_div #(
		.W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sp_q),
		.divisor  (spl_nx),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= 1'b0;
			byte_q      <= '0;
			phase_q     <= PH_START;
			style_q     <= STYLE_UNSET;
			sp_q        <= '0;
			tb_q        <= '0;
			spl_q       <= '0;
			depth_q     <= '0;
			line_q      <= 16'd1;
			halted_q    <= 1'b0;
			level_q     <= '0;
			err_q       <= ERR_NONE;
			tok_valid_q <= 1'b0;
			tok_kind_q  <= TK_INDENT;
			tok_err_q   <= ERR_NONE;
			tok_line_q  <= 16'd1;
			tok_last_q  <= 1'b0;
		end else begin
			tok_valid_q <= tok_load || (tok_valid_q && tok_stall);
			if (tok_load) begin
				tok_line_q <= line_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (src_valid) begin
						cmd_q   <= command;
						byte_q  <= source_byte;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					priority if (halted_q) begin
						state_q <= S_IDLE;
					end else if (cmd_q) begin
						if (phase_q == PH_BODY) begin
							state_q <= S_NEWLINE;
						end else begin
							if (phase_q != PH_START) begin
								line_q <= line_inc;
							end
							state_q <= S_END;
						end
					end else if (is_nl) begin
						if (phase_q == PH_BODY) begin
							state_q <= S_NEWLINE;
						end else begin
							line_q  <= line_inc;
							sp_q    <= '0;
							tb_q    <= '0;
							phase_q <= PH_START;
							state_q <= S_IDLE;
						end
					end else if ((phase_q == PH_BODY) || (phase_q == PH_SKIP)) begin
						state_q <= S_IDLE;
					end else if (is_sp) begin
						if (sp_q != CNT_W'(COUNT_CAP)) begin
							sp_q <= sp_q + CNT_W'(1);
						end
						phase_q <= PH_LEAD;
						state_q <= S_IDLE;
					end else if (is_tab) begin
						if (tb_q != CNT_W'(COUNT_CAP)) begin
							tb_q <= tb_q + CNT_W'(1);
						end
						phase_q <= PH_LEAD;
						state_q <= S_IDLE;
					end else if (is_ws) begin
						phase_q <= PH_LEAD;
						state_q <= S_IDLE;
					end else if (is_comment) begin
						phase_q <= PH_SKIP;
						state_q <= S_IDLE;
					end else begin
						phase_q <= PH_BODY;
						style_q <= style_nx;
						spl_q   <= spl_nx;
						if (mixed) begin
							err_q   <= ERR_MIXED;
							state_q <= S_ERROR;
						end else if (style_nx == STYLE_SPACES) begin
							if (spl_nx == '0) begin
								err_q   <= ERR_NOT_MULT;
								state_q <= S_ERROR;
							end else begin
								state_q <= S_DIVIDE;
							end
						end else begin
							level_q <= LW'(tb_q);
							state_q <= S_JUDGE;
						end
					end
				end
				S_DIVIDE: begin
					if (div_done) begin
						if (div_rem != '0) begin
							err_q   <= ERR_NOT_MULT;
							state_q <= S_ERROR;
						end else begin
							level_q <= LW'(div_quo);
							state_q <= S_JUDGE;
						end
					end
				end
				S_JUDGE: begin
					priority if (level_q > depth_ext) begin
						if (level_q != depth_ext + LW'(1)) begin
							err_q   <= ERR_JUMP;
							state_q <= S_ERROR;
						end else if (depth_q == DW'(MAX_DEPTH - 1)) begin
							err_q   <= ERR_DEEP;
							state_q <= S_ERROR;
						end else begin
							state_q <= S_INDENT;
						end
					end else if (level_q < depth_ext) begin
						state_q <= S_DEDENT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_INDENT: begin
					if (slot_free) begin
						tok_kind_q <= TK_INDENT;
						tok_err_q  <= ERR_NONE;
						tok_last_q <= 1'b1;
						depth_q    <= depth_q + DW'(1);
						state_q    <= S_IDLE;
					end
				end
				S_DEDENT: begin
					if (slot_free) begin
						tok_kind_q <= TK_DEDENT;
						tok_err_q  <= ERR_NONE;
						tok_last_q <= (depth_ext - LW'(1) == level_q);
						depth_q    <= depth_q - DW'(1);
						if (depth_ext - LW'(1) == level_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_NEWLINE: begin
					if (slot_free) begin
						tok_kind_q <= TK_NEWLINE;
						tok_err_q  <= ERR_NONE;
						tok_last_q <= !cmd_q;
						line_q     <= line_inc;
						sp_q       <= '0;
						tb_q       <= '0;
						phase_q    <= PH_START;
						state_q    <= cmd_q ? S_END : S_IDLE;
					end
				end
				S_END: begin
					if (slot_free) begin
						tok_kind_q <= TK_END;
						tok_err_q  <= ERR_NONE;
						tok_last_q <= 1'b1;
						phase_q    <= PH_START;
						style_q    <= STYLE_UNSET;
						sp_q       <= '0;
						tb_q       <= '0;
						spl_q      <= '0;
						depth_q    <= '0;
						line_q     <= 16'd1;
						state_q    <= S_IDLE;
					end
				end
				S_ERROR: begin
					if (slot_free) begin
						tok_kind_q <= TK_ERROR;
						tok_err_q  <= err_q;
						tok_last_q <= 1'b1;
						halted_q   <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign tok_valid   = tok_valid_q;
	assign token_kind  = tok_kind_q;
	assign error_code  = tok_err_q;
	assign line_number = tok_line_q;
	assign last_of_run = tok_last_q;

	a_no_token_when_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !tok_load)
		else $error("token emitted after error halt");

	a_dedent_below_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEDENT) |-> (level_q < depth_ext))
		else $error("dedent run past target level");

	a_space_style_has_width: assert property (@(posedge clk) disable iff (!arst_n)
		(style_q == STYLE_SPACES) |-> (spl_q != '0))
		else $error("space style without spaces per level");

	a_depth_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(depth_q) < MAX_DEPTH)
		else $error("indent depth out of range");

	a_divider_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVIDE))
		else $error("divider result with no line waiting on it");

endmodule

`default_nettype wire

// File: bench/indent_layout_tokenizer_top_test.sv
`timescale 1ns / 1ps

module indent_layout_tokenizer_top_test;
	import ilt_pkg::*;

	localparam int COUNT_CAP = (ILT_MAX_LINE_LEN - 1 < ILT_COUNT_LIMIT) ?
		ILT_MAX_LINE_LEN - 1 : ILT_COUNT_LIMIT;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam int LONG_HOLD = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 360;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  code;
		logic [15:0] line;
		logic        last;
	} token_t;

	typedef struct {
		phase_t      phase;
		logic [9:0]  spaces;
		logic [9:0]  tabs;
		style_t      style;
		logic [9:0]  spl;
		logic [4:0]  depth;
		logic [15:0] line;
		bit          halted;
	} layout_t;

	typedef struct {
		logic       cmd;
		logic [7:0] b;
		bit         fast;
		bit         drain;
	} src_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic command = 1'b0;
	logic [7:0] source_byte = 8'h00;
	logic tok_stall = 1'b0;
	logic src_stall;
	logic tok_valid;
	logic [2:0] token_kind;
	logic [2:0] error_code;
	logic [15:0] line_number;
	logic last_of_run;

	indent_layout_tokenizer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.command(command),
		.source_byte(source_byte),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.token_kind(token_kind),
		.error_code(error_code),
		.line_number(line_number),
		.last_of_run(last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	src_item_t source_requests[$];
	token_t pending_tokens[$];
	layout_t layout_state;
	layout_t shaper_state;
	style_t doc_style;
	int doc_spl;
	int shaped_items = 0;
	int queued_items = 0;
	int requests_taken = 0;
	int tokens_checked = 0;
	int longest_run = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int gap_left = 0;
	int stretch_left = 0;
	bit sender_burst = 1'b0;
	bit long_hold_done = 1'b0;
	bit src_took = 1'b0;
	logic [2:0] closing_code;
	src_item_t next_req;
	token_t want;
	int run_start;

	function automatic layout_t layout_reset();
		layout_t s;
		s.phase = PH_START;
		s.spaces = '0;
		s.tabs = '0;
		s.style = STYLE_UNSET;
		s.spl = '0;
		s.depth = '0;
		s.line = 16'd1;
		s.halted = 1'b0;
		return s;
	endfunction

	function automatic token_t make_token(logic [2:0] k, logic [2:0] c, logic [15:0] ln);
		token_t t;
		t.kind = k;
		t.code = c;
		t.line = ln;
		t.last = 1'b0;
		return t;
	endfunction

	// One request through the layout rules; tokens it causes go onto toks.
	function automatic void advance_layout(ref layout_t s, input logic cmd,
		input logic [7:0] b, ref token_t toks[$]);
		token_t made[$];
		logic [2:0] err;
		int lvl;
		int d;
		if (s.halted)
			return;
		err = ERR_NONE;
		if (cmd) begin
			if (s.phase == PH_BODY)
				made.push_back(make_token(TK_NEWLINE, ERR_NONE, s.line));
			if (s.phase != PH_START && s.line != 16'hFFFF)
				s.line++;
			made.push_back(make_token(TK_END, ERR_NONE, s.line));
			s = layout_reset();
		end else if (b == CH_NL) begin
			if (s.phase == PH_BODY)
				made.push_back(make_token(TK_NEWLINE, ERR_NONE, s.line));
			if (s.line != 16'hFFFF)
				s.line++;
			s.spaces = '0;
			s.tabs = '0;
			s.phase = PH_START;
		end else if (s.phase == PH_START || s.phase == PH_LEAD) begin
			if (b == CH_SPACE) begin
				if (s.spaces < COUNT_CAP)
					s.spaces++;
				s.phase = PH_LEAD;
			end else if (b == CH_TAB) begin
				if (s.tabs < COUNT_CAP)
					s.tabs++;
				s.phase = PH_LEAD;
			end else if (b >= CH_VT && b <= CH_CR) begin
				s.phase = PH_LEAD;
			end else if (b == CH_COMMENT || b == CH_NUL) begin
				s.phase = PH_SKIP;
			end else begin
				s.phase = PH_BODY;
				// first purely spaced or purely tabbed line fixes the style
				if (s.style == STYLE_UNSET && ((s.spaces != 0) != (s.tabs != 0))) begin
					if (s.spaces != 0) begin
						s.style = STYLE_SPACES;
						s.spl = s.spaces;
					end else begin
						s.style = STYLE_TABS;
					end
				end
				d = s.depth;
				if (s.spaces != 0 && s.tabs != 0) begin
					err = ERR_MIXED;
				end else if (s.style == STYLE_SPACES && (s.spl == 0 || s.spaces % s.spl != 0)) begin
					err = ERR_NOT_MULT;
				end else begin
					lvl = (s.style == STYLE_SPACES) ? int'(s.spaces / s.spl) : int'(s.tabs);
					if (lvl > d + 1) begin
						err = ERR_JUMP;
					end else if (lvl == d + 1 && d + 1 >= ILT_MAX_DEPTH) begin
						err = ERR_DEEP;
					end else if (lvl == d + 1) begin
						s.depth++;
						made.push_back(make_token(TK_INDENT, ERR_NONE, s.line));
					end else begin
						while (s.depth > lvl) begin
							s.depth--;
							made.push_back(make_token(TK_DEDENT, ERR_NONE, s.line));
						end
					end
				end
				if (err != ERR_NONE) begin
					s.halted = 1'b1;
					made.push_back(make_token(TK_ERROR, err, s.line));
				end
			end
		end
		if (made.size() > 0)
			made[made.size() - 1].last = 1'b1;
		foreach (made[i])
			toks.push_back(made[i]);
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Queue one request. Unless the error is wanted, a byte that would trip the
	// block is turned into a newline so the run is not halted early.
	task automatic put(input logic cmd, input logic [7:0] b, input bit fast = 1'b0,
		input bit may_fail = 1'b0);
		layout_t trial;
		token_t toks[$];
		bit trips;
		src_item_t it;
		trial = shaper_state;
		advance_layout(trial, cmd, b, toks);
		trips = 1'b0;
		foreach (toks[i])
			if (toks[i].kind == TK_ERROR)
				trips = 1'b1;
		if (trips && !may_fail) begin
			cmd = 1'b0;
			b = CH_NL;
			trial = shaper_state;
			toks.delete();
			advance_layout(trial, cmd, b, toks);
		end
		if (!shaper_state.halted && (cmd || b == CH_NL || shaper_state.phase == PH_START ||
			shaper_state.phase == PH_LEAD))
			shaped_items++;
		queued_items++;
		shaper_state = trial;
		it.cmd = cmd;
		it.b = b;
		it.fast = fast;
		it.drain = 1'b0;
		source_requests.push_back(it);
	endtask

	task automatic put_text(input string t, input bit may_fail = 1'b0);
		for (int i = 0; i < t.len(); i++)
			put(1'b0, t[i], 1'b0, may_fail);
	endtask

	task automatic put_drain();
		src_item_t it;
		it.cmd = 1'b0;
		it.b = 8'h00;
		it.fast = 1'b0;
		it.drain = 1'b1;
		source_requests.push_back(it);
	endtask

	function automatic logic [7:0] lead_char();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			3: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do
			b = $urandom_range(0, 255);
		while (b == CH_NL);
		return b;
	endfunction

	function automatic logic [7:0] content_byte();
		logic [7:0] b;
		do
			b = $urandom_range(1, 255);
		while (b == CH_TAB || (b >= CH_NL && b <= CH_CR) || b == CH_SPACE || b == CH_COMMENT);
		return b;
	endfunction

	// n indent characters with CR, VT or FF sprinkled in (they count as nothing)
	task automatic put_lead(input int n, input logic [7:0] ch);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				put(1'b0, 8'(CH_VT + $urandom_range(0, 2)));
			put(1'b0, ch);
		end
	endtask

	task automatic put_line(input int lvl);
		style_t st;
		int spl;
		st = (shaper_state.style == STYLE_UNSET) ? doc_style : shaper_state.style;
		spl = (shaper_state.style == STYLE_SPACES) ? int'(shaper_state.spl) : doc_spl;
		if (lvl == 0 && shaper_state.style != STYLE_UNSET && $urandom_range(0, 4) == 0)
			// the character of the other style is ignored
			put_lead($urandom_range(1, 6), (st == STYLE_TABS) ? CH_SPACE : CH_TAB);
		else if (st == STYLE_TABS)
			put_lead(lvl, CH_TAB);
		else
			put_lead(lvl * spl, CH_SPACE);
		put(1'b0, content_byte());
		repeat ($urandom_range(0, 8))
			put(1'b0, body_byte());
		put(1'b0, CH_NL);
	endtask

	task automatic random_document();
		int kind;
		int lvl;
		int d;
		int r;
		doc_style = $urandom_range(0, 1) ? STYLE_TABS : STYLE_SPACES;
		doc_spl = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
		repeat ($urandom_range(2, 12)) begin
			kind = $urandom_range(0, 99);
			d = shaper_state.depth;
			if (kind < 8) begin
				repeat ($urandom_range(0, 4))
					put(1'b0, lead_char());
				put(1'b0, CH_NL);
			end else if (kind < 16) begin
				repeat ($urandom_range(0, 3))
					put(1'b0, lead_char());
				put(1'b0, $urandom_range(0, 1) ? CH_COMMENT : CH_NUL);
				repeat ($urandom_range(0, 6))
					put(1'b0, body_byte());
				put(1'b0, CH_NL);
			end else if (kind < 24) begin
				repeat ($urandom_range(1, 10))
					put(1'b0, 8'($urandom_range(0, 255)));
			end else begin
				r = $urandom_range(0, 9);
				lvl = (r < 4) ? d + 1 : (r < 7) ? d : $urandom_range(0, d);
				if (lvl >= ILT_MAX_DEPTH)
					lvl = d;
				put_line(lvl);
			end
		end
		// leave the last line open now and then
		r = $urandom_range(0, 3);
		if (r == 0)
			put(1'b0, content_byte());
		else if (r == 1)
			put(1'b0, lead_char());
		put(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic climb_to_top(input int levels);
		for (int k = 1; k <= levels; k++) begin
			repeat (k)
				put(1'b0, CH_TAB, 1'b1);
			put(1'b0, content_byte());
			put(1'b0, CH_NL);
		end
	endtask

	// sender: new request or gap at each falling edge once the last one went in
	always @(negedge clk) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!src_valid || src_took) begin
			if (gap_left > 0) begin
				gap_left--;
				src_valid <= 1'b0;
			end else if (source_requests.size() > 0 && source_requests[0].drain) begin
				src_valid <= 1'b0;
				if (pending_tokens.size() == 0)
					void'(source_requests.pop_front());
			end else if (source_requests.size() > 0) begin
				next_req = source_requests.pop_front();
				src_valid <= 1'b1;
				command <= next_req.cmd;
				source_byte <= next_req.b;
				if (!next_req.fast && !sender_burst && $urandom_range(0, 1) == 1)
					gap_left = idle_len();
				if ($urandom_range(0, 99) == 0)
					sender_burst = !sender_burst;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// receiver: stall and pass stretches, plus one long hold from the first token on
	always @(negedge clk) begin
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else if (!long_hold_done && tok_valid) begin
			long_hold_done = 1'b1;
			stretch_left = LONG_HOLD;
			tok_stall <= 1'b1;
		end else if (stretch_left > 0) begin
			stretch_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			stretch_left = idle_len() - 1;
			tok_stall <= 1'b1;
		end else begin
			stretch_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) :
				$urandom_range(0, 15);
			tok_stall <= 1'b0;
		end
	end

	function automatic void check_field(string what, int exp_val, int got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			src_took <= 1'b0;
		end else begin
			src_took <= src_valid && !src_stall;
			if (tok_valid && !tok_stall) begin
				if (pending_tokens.size() == 0) begin
					$display("%0t: unexpected token, expected none, got kind %0d line %0d",
						$time, token_kind, line_number);
					mismatches++;
				end else begin
					want = pending_tokens.pop_front();
					check_field("token_kind", want.kind, token_kind);
					check_field("error_code", want.code, error_code);
					check_field("line_number", want.line, line_number);
					check_field("last_of_run", want.last, last_of_run);
					tokens_checked++;
				end
			end
			if (src_valid && !src_stall) begin
				run_start = pending_tokens.size();
				advance_layout(layout_state, command, source_byte, pending_tokens);
				if (pending_tokens.size() - run_start > longest_run)
					longest_run = pending_tokens.size() - run_start;
				requests_taken++;
			end
			if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("indent_layout_tokenizer_top_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		layout_state = layout_reset();
		shaper_state = layout_reset();

		// directed: plain, blank, comment, NUL start, CR/FF/VT lead, space style,
		// ignored tabs, top byte, END in a body and END on an empty source
		put_text("x\n");
		put(1'b0, CH_NL);
		put_text(" ;c\n");
		put(1'b0, CH_NUL);
		put_text("z\n");
		put(1'b0, CH_CR);
		put(1'b0, CH_FF);
		put(1'b0, CH_VT);
		put_text("q\n");
		put_text("  y\n");
		put_text("\tz");
		put(1'b0, 8'hFF);
		put(1'b0, CH_NL);
		put(1'b0, 8'hFF);
		put(1'b1, 8'hFF);
		put(1'b1, 8'h00);
		put_drain();

		// nest several levels, then one line back at column 0: a dedent run
		climb_to_top(8);
		put(1'b0, content_byte());
		put(1'b0, CH_NL);
		put(1'b1, 8'h00);
		put_drain();

		begin
			int base;
			int docs;
			base = queued_items;
			docs = 0;
			while (queued_items < base + RANDOM_ITEMS) begin
				random_document();
				docs++;
				if (docs % 6 == 5)
					put_drain();
			end
		end

		// closing error: the block halts for good, later requests give nothing
		case ($urandom_range(0, 2))
			0: begin
				closing_code = ERR_MIXED;
				put_text(" \tx", 1'b1);
			end
			1: begin
				closing_code = ERR_NOT_MULT;
				put_text("  a\n   b", 1'b1);
			end
			default: begin
				closing_code = ERR_JUMP;
				put_text("\t\t\tx", 1'b1);
			end
		endcase
		put_text("tail\n");
		put(1'b1, 8'h00);

		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (source_requests.size() != 0 || src_valid)
			@(posedge clk);
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (50)
			@(posedge clk);

		$display("Fed %0d requests (%0d shaping line layout), matched %0d tokens, longest run %0d.",
			requests_taken, shaped_items, tokens_checked, longest_run);
		$display("Run closed on error code %0d, after which the block stayed silent.",
			closing_code);
		if (mismatches == 0)
			$display("indent_layout_tokenizer_top_test OK");
		else
			$display("indent_layout_tokenizer_top_test NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
design/ilt_pkg.sv
design/ilt_div.sv
design/indent_layout_tokenizer_top.sv
bench/indent_layout_tokenizer_top_test.sv
